// ===== hdl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// shared types and constants of the cartesian to spherical converter
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int SQRT_CELLS   = 32;
  localparam int NORM_CELLS   = 6;
  localparam int CORDIC_CELLS = 24;
  localparam int NORM_W       = 40;
  localparam int VEC_W        = 43;
  localparam int ACC_W        = 28;

  // prep, normalise, cordic and finish stages of one angle unit
  localparam int ANGLE_LATENCY = 1 + NORM_CELLS + CORDIC_CELLS + 1;

  localparam logic [15:0] LIMIT_RESET = 16'd7;

  localparam logic signed [ACC_W-1:0] PI_ACC      = 28'sd52707179;
  localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 28'sd26353589;
  localparam logic signed [ACC_W-1:0] ROUND_ACC   = 28'sd128;

  localparam int NORM_SHIFT [NORM_CELLS] = '{32, 16, 8, 4, 2, 1};

  localparam logic signed [ACC_W-1:0] ATAN_STEP [CORDIC_CELLS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  typedef logic [NORM_W-1:0]        norm_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic opp_zero;
    logic adj_zero;
    logic adj_neg;
  } ang_flags_t;

endpackage

// ===== hdl/c2s_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// one digit of a restoring integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module c2s_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_in,
  input  logic [33:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] rad,
  output logic [33:0] rem,
  output logic [31:0] root
);

  logic [35:0] r2;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    r2    = {rem_in, rad_in[63:62]};
    trial = {2'b00, root_in, 2'b01};
    diff  = r2 - trial;
    ge    = (r2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= {rad_in[61:0], 2'b00};
      rem  <= ge ? diff[33:0] : r2[33:0];
      root <= {root_in[30:0], ge};
    end
  end

endmodule

// ===== hdl/c2s_norm_cell.sv =====
// ----------------------------------------------------------------------------
// c2s_norm_cell
// one stage of the leading zero normalise ahead of the cordic chain
// ----------------------------------------------------------------------------
module c2s_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic                clk,
  input  logic                en,
  input  c2s_pkg::norm_t      adj_in,
  input  c2s_pkg::norm_t      opp_in,
  input  c2s_pkg::ang_flags_t flags_in,
  output c2s_pkg::norm_t      adj,
  output c2s_pkg::norm_t      opp,
  output c2s_pkg::ang_flags_t flags
);

  logic top_clear;

  always_comb begin
    top_clear = (((adj_in | opp_in) >> (c2s_pkg::NORM_W - SHIFT)) == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adj   <= top_clear ? c2s_pkg::norm_t'(adj_in << SHIFT) : adj_in;
      opp   <= top_clear ? c2s_pkg::norm_t'(opp_in << SHIFT) : opp_in;
      flags <= flags_in;
    end
  end

endmodule

// ===== hdl/c2s_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// one vectoring rotation of the cordic chain
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  c2s_pkg::vec_t       x_in,
  input  c2s_pkg::vec_t       y_in,
  input  c2s_pkg::acc_t       acc_in,
  input  c2s_pkg::ang_flags_t flags_in,
  output c2s_pkg::vec_t       x,
  output c2s_pkg::vec_t       y,
  output c2s_pkg::acc_t       acc,
  output c2s_pkg::ang_flags_t flags
);

  c2s_pkg::vec_t dx;
  c2s_pkg::vec_t dy;

  always_comb begin
    dx = y_in >>> STEP;
    dy = x_in >>> STEP;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[c2s_pkg::VEC_W-1]) begin
        x   <= x_in + dx;
        y   <= y_in - dy;
        acc <= acc_in + c2s_pkg::ATAN_STEP[STEP];
      end else begin
        x   <= x_in - dx;
        y   <= y_in + dy;
        acc <= acc_in - c2s_pkg::ATAN_STEP[STEP];
      end
      flags <= flags_in;
    end
  end

endmodule

// ===== hdl/c2s_angle.sv =====
// ----------------------------------------------------------------------------
// c2s_angle
// atan2 of a non-negative opposite side and a signed adjacent side, q.16 out
// ----------------------------------------------------------------------------
module c2s_angle (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        opp_side,
  input  logic signed [31:0] adj_side,
  output logic [17:0]        angle
);

  c2s_pkg::norm_t      prep_adj;
  c2s_pkg::norm_t      prep_opp;
  c2s_pkg::ang_flags_t prep_flags;
  logic [31:0]         adj_mag;

  c2s_pkg::norm_t      n_adj   [c2s_pkg::NORM_CELLS+1];
  c2s_pkg::norm_t      n_opp   [c2s_pkg::NORM_CELLS+1];
  c2s_pkg::ang_flags_t n_flags [c2s_pkg::NORM_CELLS+1];

  c2s_pkg::vec_t       c_x     [c2s_pkg::CORDIC_CELLS+1];
  c2s_pkg::vec_t       c_y     [c2s_pkg::CORDIC_CELLS+1];
  c2s_pkg::acc_t       c_acc   [c2s_pkg::CORDIC_CELLS+1];
  c2s_pkg::ang_flags_t c_flags [c2s_pkg::CORDIC_CELLS+1];

  c2s_pkg::acc_t       fin_acc;
  c2s_pkg::acc_t       fin_round;
  c2s_pkg::ang_flags_t fin_flags;

  always_comb begin
    adj_mag = adj_side[31] ? 32'(-adj_side) : 32'(adj_side);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_adj            <= {8'b0, adj_mag};
      prep_opp            <= {8'b0, opp_side};
      prep_flags.opp_zero <= (opp_side == '0);
      prep_flags.adj_zero <= (adj_side == '0);
      prep_flags.adj_neg  <= adj_side[31];
    end
  end

  assign n_adj[0]   = prep_adj;
  assign n_opp[0]   = prep_opp;
  assign n_flags[0] = prep_flags;

  for (genvar k = 0; k < c2s_pkg::NORM_CELLS; k++) begin : g_norm
    c2s_norm_cell #(
      .SHIFT(c2s_pkg::NORM_SHIFT[k])
    ) u_norm (
      .clk      (clk),
      .en       (en),
      .adj_in   (n_adj[k]),
      .opp_in   (n_opp[k]),
      .flags_in (n_flags[k]),
      .adj      (n_adj[k+1]),
      .opp      (n_opp[k+1]),
      .flags    (n_flags[k+1])
    );
  end

  assign c_x[0]     = {3'b000, n_adj[c2s_pkg::NORM_CELLS]};
  assign c_y[0]     = {3'b000, n_opp[c2s_pkg::NORM_CELLS]};
  assign c_acc[0]   = '0;
  assign c_flags[0] = n_flags[c2s_pkg::NORM_CELLS];

  for (genvar k = 0; k < c2s_pkg::CORDIC_CELLS; k++) begin : g_cordic
    c2s_cordic_cell #(
      .STEP(k)
    ) u_cordic (
      .clk      (clk),
      .en       (en),
      .x_in     (c_x[k]),
      .y_in     (c_y[k]),
      .acc_in   (c_acc[k]),
      .flags_in (c_flags[k]),
      .x        (c_x[k+1]),
      .y        (c_y[k+1]),
      .acc      (c_acc[k+1]),
      .flags    (c_flags[k+1])
    );
  end

  // clamp to the first quadrant, mirror, then special cases
  always_comb begin
    fin_flags = c_flags[c2s_pkg::CORDIC_CELLS];
    fin_acc   = c_acc[c2s_pkg::CORDIC_CELLS];
    if (fin_acc < 0) begin
      fin_acc = '0;
    end
    if (fin_acc > c2s_pkg::HALF_PI_ACC) begin
      fin_acc = c2s_pkg::HALF_PI_ACC;
    end
    if (fin_flags.adj_neg) begin
      fin_acc = c2s_pkg::PI_ACC - fin_acc;
    end
    if (fin_flags.opp_zero) begin
      fin_acc = fin_flags.adj_neg ? c2s_pkg::PI_ACC : '0;
    end else if (fin_flags.adj_zero) begin
      fin_acc = c2s_pkg::HALF_PI_ACC;
    end
    fin_round = fin_acc + c2s_pkg::ROUND_ACC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= fin_round[25:8];
    end
  end

endmodule

// ===== hdl/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// converts a signed q15.16 point to polar angle, azimuth angle and radius
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with coord_x, coord_y, coord_z.
// output channel: out_valid / out_stall with polar_angle, azimuth_angle and
// radius. a transfer happens on a clock edge with valid high and stall low.
// one point is taken each cycle while in_stall is low; each result passes through
// these registers in order: the squares are registered at the transfer edge,
// then a summing register, 32 square root cells, the angle pipeline
// (prepare, normalise, 24 cordic cells, round) and the output register.
// cfg_write_enable with cfg_write_data sets the near zero limit (reset 7);
// write it only while no point is in flight.
// synchronous rst empties the pipeline and the output side.
// while out_stall holds a result, one more result is caught in a skid
// register; in_stall then rises and the whole pipeline holds until the
// output moves again.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [17:0]        polar_angle,
  output logic signed [18:0] azimuth_angle,
  output logic [31:0]        radius,
  input  logic               cfg_write_enable,
  input  logic [15:0]        cfg_write_data
);

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] radius;
    logic [31:0] planar;
    logic        z_neg;
  } res_side_t;

  logic [15:0] near_zero_limit;
  logic        en;

  pt_side_t    sq_side;
  logic [63:0] sq_x;
  logic [63:0] sq_y;
  logic [63:0] sq_z;

  pt_side_t    sum_side [c2s_pkg::SQRT_CELLS+1];
  logic [63:0] sum3;
  logic [63:0] sum2;

  logic [63:0] rad3  [c2s_pkg::SQRT_CELLS+1];
  logic [33:0] rem3  [c2s_pkg::SQRT_CELLS+1];
  logic [31:0] root3 [c2s_pkg::SQRT_CELLS+1];
  logic [63:0] rad2  [c2s_pkg::SQRT_CELLS+1];
  logic [33:0] rem2  [c2s_pkg::SQRT_CELLS+1];
  logic [31:0] root2 [c2s_pkg::SQRT_CELLS+1];

  res_side_t   res_head;
  res_side_t   res_side [c2s_pkg::ANGLE_LATENCY];
  pt_side_t    sqrt_out;
  logic [31:0] z_mag;
  logic [17:0] pol_ang;
  logic [17:0] az_ang;

  res_side_t          fin;
  logic [17:0]        fin_polar;
  logic signed [18:0] fin_azim;
  logic signed [18:0] az_mag;

  logic               skid_valid;
  logic [17:0]        skid_polar;
  logic signed [18:0] skid_azim;
  logic [31:0]        skid_radius;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_zero_limit <= c2s_pkg::LIMIT_RESET;
    end else if (cfg_write_enable) begin
      near_zero_limit <= cfg_write_data;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side.valid <= 1'b0;
    end else if (en) begin
      sq_side.valid <= in_valid;
      sq_side.x     <= coord_x;
      sq_side.y     <= coord_y;
      sq_side.z     <= coord_z;
      sq_x          <= 64'(coord_x * coord_x);
      sq_y          <= 64'(coord_y * coord_y);
      sq_z          <= 64'(coord_z * coord_z);
    end
  end

  // sums of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= sq_x + sq_y + sq_z;
      sum2 <= sq_x + sq_z;
    end
  end

  assign rad3[0]  = sum3;
  assign rem3[0]  = '0;
  assign root3[0] = '0;
  assign rad2[0]  = sum2;
  assign rem2[0]  = '0;
  assign root2[0] = '0;

  for (genvar k = 0; k < c2s_pkg::SQRT_CELLS; k++) begin : g_sqrt
    c2s_sqrt_cell u_len3 (
      .clk     (clk),
      .en      (en),
      .rad_in  (rad3[k]),
      .rem_in  (rem3[k]),
      .root_in (root3[k]),
      .rad     (rad3[k+1]),
      .rem     (rem3[k+1]),
      .root    (root3[k+1])
    );
    c2s_sqrt_cell u_len2 (
      .clk     (clk),
      .en      (en),
      .rad_in  (rad2[k]),
      .rem_in  (rem2[k]),
      .root_in (root2[k]),
      .rad     (rad2[k+1]),
      .rem     (rem2[k+1]),
      .root    (root2[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= c2s_pkg::SQRT_CELLS; k++) begin
        sum_side[k].valid <= 1'b0;
      end
    end else if (en) begin
      sum_side[0] <= sq_side;
      for (int k = 1; k <= c2s_pkg::SQRT_CELLS; k++) begin
        sum_side[k] <= sum_side[k-1];
      end
    end
  end

  assign sqrt_out = sum_side[c2s_pkg::SQRT_CELLS];
  assign z_mag    = sqrt_out.z[31] ? 32'(-sqrt_out.z) : 32'(sqrt_out.z);

  c2s_angle u_polar (
    .clk      (clk),
    .en       (en),
    .opp_side (root2[c2s_pkg::SQRT_CELLS]),
    .adj_side (sqrt_out.y),
    .angle    (pol_ang)
  );

  c2s_angle u_azim (
    .clk      (clk),
    .en       (en),
    .opp_side (z_mag),
    .adj_side (sqrt_out.x),
    .angle    (az_ang)
  );

  always_comb begin
    res_head.valid  = sqrt_out.valid;
    res_head.radius = root3[c2s_pkg::SQRT_CELLS];
    res_head.planar = root2[c2s_pkg::SQRT_CELLS];
    res_head.z_neg  = sqrt_out.z[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < c2s_pkg::ANGLE_LATENCY; k++) begin
        res_side[k].valid <= 1'b0;
      end
    end else if (en) begin
      res_side[0] <= res_head;
      for (int k = 1; k < c2s_pkg::ANGLE_LATENCY; k++) begin
        res_side[k] <= res_side[k-1];
      end
    end
  end

  // near zero forcing and azimuth sign
  always_comb begin
    fin       = res_side[c2s_pkg::ANGLE_LATENCY-1];
    az_mag    = {1'b0, az_ang};
    fin_polar = (fin.radius >= {16'b0, near_zero_limit}) ? pol_ang : '0;
    if (fin.planar >= {16'b0, near_zero_limit}) begin
      fin_azim = fin.z_neg ? -az_mag : az_mag;
    end else begin
      fin_azim = '0;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid     <= 1'b1;
        polar_angle   <= skid_polar;
        azimuth_angle <= skid_azim;
        radius        <= skid_radius;
        skid_valid    <= 1'b0;
      end else begin
        out_valid     <= fin.valid;
        polar_angle   <= fin_polar;
        azimuth_angle <= fin_azim;
        radius        <= fin.radius;
      end
    end else if (fin.valid && !skid_valid) begin
      skid_valid  <= 1'b1;
      skid_polar  <= fin_polar;
      skid_azim   <= fin_azim;
      skid_radius <= fin.radius;
    end
  end

endmodule

// ===== hdl/c2s_checker.sv =====
// ----------------------------------------------------------------------------
// c2s_checker
// port level checks of the cartesian to spherical converter
// ----------------------------------------------------------------------------
module c2s_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [17:0]        polar_angle,
  input logic signed [18:0] azimuth_angle,
  input logic [31:0]        radius
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(polar_angle)
      && $stable(azimuth_angle) && $stable(radius))
    else $error("stalled transfer changed");

  a_polar_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> polar_angle <= 18'd205887)
    else $error("polar angle beyond pi");

  a_azim_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> azimuth_angle <= 19'sd205887 && azimuth_angle >= -19'sd205887)
    else $error("azimuth angle beyond pi");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
